// ===== design/vector4_normalize_core_macros.svh =====
// ----------------------------------------------------------------------------
// vector4_normalize_core_macros.svh
// Assertion macros shared by the vector normalize block.
// ----------------------------------------------------------------------------
`ifndef VECTOR4_NORMALIZE_CORE_MACROS_SVH
`define VECTOR4_NORMALIZE_CORE_MACROS_SVH

// same-cycle implication, checked on clk, quiet during reset
`define V4N_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("v4n check failed");

// next-cycle implication, checked on clk, quiet during reset
`define V4N_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("v4n check failed");

`endif

// ===== design/v4n_pkg.sv =====
// ----------------------------------------------------------------------------
// v4n_pkg
// Widths and shared types of the four-component vector normalize pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package v4n_pkg;

	localparam int COMP_BITS      = 16;
	localparam int UNIT_FRAC_BITS = 14;
	localparam int LEN_BITS       = COMP_BITS + 1;
	localparam int UNIT_BITS      = UNIT_FRAC_BITS + 2;
	localparam int MAG_BITS       = COMP_BITS;
	localparam int SQ_BITS        = 2 * MAG_BITS;
	localparam int SUM_BITS       = 2 * COMP_BITS + 1;
	// radicand padded to an even width, one root bit per stage
	localparam int RAD_BITS       = 2 * LEN_BITS;
	localparam int SQRT_STEPS     = LEN_BITS;
	localparam int REM_BITS       = LEN_BITS + 2;
	localparam int DIV_STEPS      = UNIT_FRAC_BITS + 1;
	localparam int QUO_BITS       = UNIT_FRAC_BITS + 1;

	typedef logic [COMP_BITS-1:0] comp_t;
	typedef logic [MAG_BITS-1:0]  mag_t;
	typedef logic [UNIT_BITS-1:0] unit_t;
	typedef logic [LEN_BITS-1:0]  len_t;
	typedef logic [SUM_BITS-1:0]  sum_t;

	// component magnitudes and signs that ride along with each vector
	typedef struct packed {
		mag_t [3:0] mag;
		logic [3:0] neg;
	} side_t;

endpackage

// ===== design/v4n_square_sum.sv =====
// ----------------------------------------------------------------------------
// v4n_square_sum
// Two stages: component magnitudes and squares, then the sum of squares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module v4n_square_sum (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_vld,
	input  v4n_pkg::comp_t [3:0]     comp,
	output logic                     vld,
	output v4n_pkg::sum_t            sum,
	output v4n_pkg::side_t           side
);
	import v4n_pkg::*;

	logic                     vld_s1, vld_s2;
	side_t                    side_s1, side_s2;
	logic [3:0][SQ_BITS-1:0]  sq_s1;
	sum_t                     sum_s2;
	side_t                    side_c;

	// magnitude and sign of each lane
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			side_c.neg[i] = comp[i][COMP_BITS-1];
			side_c.mag[i] = comp[i][COMP_BITS-1] ? (~comp[i] + 1'b1) : comp[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1 squares, stage 2 adds
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c;
			for (int i = 0; i < 4; i++)
				sq_s1[i] <= SQ_BITS'(side_c.mag[i]) * SQ_BITS'(side_c.mag[i]);
			side_s2 <= side_s1;
			sum_s2  <= SUM_BITS'(sq_s1[0]) + SUM_BITS'(sq_s1[1])
				+ SUM_BITS'(sq_s1[2]) + SUM_BITS'(sq_s1[3]);
		end
	end

	assign vld  = vld_s2;
	assign sum  = sum_s2;
	assign side = side_s2;

endmodule

// ===== design/v4n_sqrt.sv =====
// ----------------------------------------------------------------------------
// v4n_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module v4n_sqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  v4n_pkg::sum_t    sum,
	input  v4n_pkg::side_t   in_side,
	output logic             vld,
	output v4n_pkg::len_t    root,
	output v4n_pkg::side_t   side
);
	import v4n_pkg::*;

	logic                 vld_s  [SQRT_STEPS+1];
	logic [RAD_BITS-1:0]  rad_s  [SQRT_STEPS+1];
	logic [REM_BITS-1:0]  rem_s  [SQRT_STEPS+1];
	len_t                 root_s [SQRT_STEPS+1];
	side_t                side_s [SQRT_STEPS+1];

	assign vld_s[0]  = in_vld;
	assign rad_s[0]  = RAD_BITS'(sum);
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		logic [REM_BITS+1:0] shifted;
		logic [REM_BITS+1:0] trial;
		logic                take;

		// bring down the next two radicand bits and try root*4+1
		always_comb begin
			shifted = {rem_s[k], rad_s[k][RAD_BITS-1 -: 2]};
			trial   = (REM_BITS+2)'({root_s[k], 2'b01});
			take    = shifted >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_s[k][RAD_BITS-3:0], 2'b00};
				rem_s[k+1]  <= take ? REM_BITS'(shifted - trial) : REM_BITS'(shifted);
				root_s[k+1] <= {root_s[k][LEN_BITS-2:0], take};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vld  = vld_s[SQRT_STEPS];
	assign root = root_s[SQRT_STEPS];
	assign side = side_s[SQRT_STEPS];

endmodule

// ===== design/v4n_divide.sv =====
// ----------------------------------------------------------------------------
// v4n_divide
// Four-lane pipelined restoring divide of magnitude by length, with
// saturation, sign restore and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module v4n_divide (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  v4n_pkg::len_t         len,
	input  v4n_pkg::side_t        in_side,
	output logic                  vld,
	output v4n_pkg::len_t         len_out,
	output v4n_pkg::unit_t [3:0]  unit,
	output logic                  zero
);
	import v4n_pkg::*;

	localparam logic [QUO_BITS-1:0] ONE = QUO_BITS'(1) << UNIT_FRAC_BITS;

	logic                       vld_s  [DIV_STEPS+1];
	len_t                       len_s  [DIV_STEPS+1];
	logic [3:0]                 neg_s  [DIV_STEPS+1];
	logic [3:0]                 sat_s  [DIV_STEPS+1];
	logic [3:0]                 lsb_s  [DIV_STEPS+1];
	len_t [3:0]                 rem_s  [DIV_STEPS+1];
	logic [3:0][QUO_BITS-1:0]   quo_s  [DIV_STEPS+1];

	logic                       vld_q;
	len_t                       len_q;
	unit_t [3:0]                unit_q;
	logic                       zero_q;

	// entry: saturate when mag >= 2*len, else start remainder at mag/2 (< len)
	always_comb begin
		vld_s[0] = in_vld;
		len_s[0] = len;
		for (int i = 0; i < 4; i++) begin
			neg_s[0][i] = in_side.neg[i];
			sat_s[0][i] = (LEN_BITS+1)'(in_side.mag[i]) >= {len, 1'b0};
			lsb_s[0][i] = in_side.mag[i][0];
			rem_s[0][i] = LEN_BITS'(in_side.mag[i] >> 1);
			quo_s[0][i] = '0;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [3:0][LEN_BITS:0] part;
		logic [3:0]             take;

		// the first step brings down the magnitude's low bit, the rest zeros
		always_comb begin
			for (int i = 0; i < 4; i++) begin
				part[i] = {rem_s[k][i], (k == 0) ? lsb_s[k][i] : 1'b0};
				take[i] = part[i] >= (LEN_BITS+1)'(len_s[k]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_s[k+1] <= len_s[k];
				neg_s[k+1] <= neg_s[k];
				sat_s[k+1] <= sat_s[k];
				lsb_s[k+1] <= lsb_s[k];
				for (int i = 0; i < 4; i++) begin
					rem_s[k+1][i] <= take[i]
						? LEN_BITS'(part[i] - (LEN_BITS+1)'(len_s[k]))
						: LEN_BITS'(part[i]);
					quo_s[k+1][i] <= {quo_s[k][i][QUO_BITS-2:0], take[i]};
				end
			end
		end
	end

	// clamp, restore sign, zero-length override
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (en)
			vld_q <= vld_s[DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		logic [QUO_BITS-1:0] mq;
		logic                is_zero;
		if (en) begin
			is_zero = len_s[DIV_STEPS] == '0;
			len_q   <= len_s[DIV_STEPS];
			zero_q  <= is_zero;
			for (int i = 0; i < 4; i++) begin
				mq = (sat_s[DIV_STEPS][i] || quo_s[DIV_STEPS][i] > ONE)
					? ONE : quo_s[DIV_STEPS][i];
				if (is_zero)
					unit_q[i] <= '0;
				else if (neg_s[DIV_STEPS][i])
					unit_q[i] <= ~UNIT_BITS'(mq) + 1'b1;
				else
					unit_q[i] <= UNIT_BITS'(mq);
			end
		end
	end

	assign vld     = vld_q;
	assign len_out = len_q;
	assign unit    = unit_q;
	assign zero    = zero_q;

endmodule

// ===== design/vector4_normalize_core.sv =====
// ----------------------------------------------------------------------------
// vector4_normalize_core
// Length and unit vector of a four-component signed Q8.8 vector.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid in_ready comp_x/y/z/w       | to block
//  out     | out_valid out_ready vec_length       | from block
//          | unit_x/y/z/w zero_length             |
//
// One vector per cycle unless stalled at out_ready. The stages are squares and
// sum, one square-root bit per stage, one quotient bit per stage, then the
// output register.
// The whole pipeline advances together; a stall at out_ready holds every
// stage, and in_ready drops only when the output register is full and held.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector4_normalize_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  v4n_pkg::comp_t      comp_x,
	input  v4n_pkg::comp_t      comp_y,
	input  v4n_pkg::comp_t      comp_z,
	input  v4n_pkg::comp_t      comp_w,
	output logic                out_valid,
	input  logic                out_ready,
	output v4n_pkg::len_t       vec_length,
	output v4n_pkg::unit_t      unit_x,
	output v4n_pkg::unit_t      unit_y,
	output v4n_pkg::unit_t      unit_z,
	output v4n_pkg::unit_t      unit_w,
	output logic                zero_length
);
	import v4n_pkg::*;

	`include "vector4_normalize_core_macros.svh"

	logic          en;
	logic          ss_vld, sq_vld;
	sum_t          ss_sum;
	side_t         ss_side, sq_side;
	len_t          sq_root;
	comp_t [3:0]   comp;
	unit_t [3:0]   unit;

	// global advance: move when the output register is empty or drained
	assign en       = out_ready || !out_valid;
	assign in_ready = en;

	assign comp = {comp_w, comp_z, comp_y, comp_x};

	v4n_square_sum u_square_sum (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (in_valid),
		.comp   (comp),
		.vld    (ss_vld),
		.sum    (ss_sum),
		.side   (ss_side)
	);

	v4n_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (ss_vld),
		.sum     (ss_sum),
		.in_side (ss_side),
		.vld     (sq_vld),
		.root    (sq_root),
		.side    (sq_side)
	);

	v4n_divide u_divide (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld),
		.len     (sq_root),
		.in_side (sq_side),
		.vld     (out_valid),
		.len_out (vec_length),
		.unit    (unit),
		.zero    (zero_length)
	);

	assign unit_x = unit[0];
	assign unit_y = unit[1];
	assign unit_z = unit[2];
	assign unit_w = unit[3];

	// output checks
	`V4N_ASSERT_IMPL(a_zero_flag, out_valid, zero_length == (vec_length == '0))
	`V4N_ASSERT_IMPL(a_zero_units, out_valid && zero_length,
		(unit_x == '0) && (unit_y == '0) && (unit_z == '0) && (unit_w == '0))
	`V4N_ASSERT_IMPL(a_unit_range, out_valid,
		($signed(unit_x) <= $signed(UNIT_BITS'(1) << UNIT_FRAC_BITS))
		&& ($signed(unit_x) >= -$signed(UNIT_BITS'(1) << UNIT_FRAC_BITS)))

endmodule
